// File: rtl/gwwb_pkg.sv
// Package: command and status codes, payload structs and state types for grey-world white balance.
package gwwb_pkg;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ACCUM = 2'd1;

    localparam logic [1:0] STAT_CLEARED = 2'd0;
    localparam logic [1:0] STAT_ACCUM   = 2'd1;
    localparam logic [1:0] STAT_APPLIED = 2'd2;
    localparam logic [1:0] STAT_DROPPED = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] chan0_in;
        logic [15:0] chan1_in;
        logic [15:0] chan2_in;
    } in_item_t;

    typedef struct packed {
        logic [15:0] chan0_out;
        logic [15:0] chan1_out;
        logic [15:0] chan2_out;
        logic [1:0]  status;
    } out_item_t;

    typedef enum logic [1:0] {
        LN_IDLE,
        LN_MUL,
        LN_DIV,
        LN_DONE
    } lane_state_t;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } top_state_t;

endpackage

// File: rtl/gwwb_lane.sv
// One channel lane: gain product, then restoring bit-serial division with round and clamp.
module gwwb_lane #(
    parameter int PIXEL_BITS = 16,
    parameter int SUM_BITS   = 40
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [PIXEL_BITS-1:0] pix_in,
    input  logic [SUM_BITS+1:0]   total_in,
    input  logic [SUM_BITS-1:0]   sum_in,
    output logic                  done,
    output logic [PIXEL_BITS-1:0] result
);
    localparam int NW = PIXEL_BITS + SUM_BITS + 4;
    localparam int DW = SUM_BITS + 3;
    localparam int CW = $clog2(NW + 1);

    gwwb_pkg::lane_state_t state_reg, state_next;
    logic [PIXEL_BITS-1:0] pix_reg, q_reg, q_next;
    logic [SUM_BITS+1:0]   tot_reg;
    logic [SUM_BITS-1:0]   sum_reg;
    logic [NW-1:0]         num_reg, num_next;
    logic [DW-1:0]         rem_reg, rem_next, div_w;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  sat_reg, sat_next;
    logic [PIXEL_BITS+SUM_BITS+1:0] prod;
    logic [DW:0]           rem_sh;
    logic                  qb;
    logic [PIXEL_BITS:0]   qn;

    assign prod   = pix_reg * tot_reg;
    assign div_w  = {sum_reg, 3'b000} - {2'b00, sum_reg, 1'b0};
    assign rem_sh = {rem_reg, num_reg[NW-1]};
    assign qb     = rem_sh >= {1'b0, div_w};
    assign qn     = {q_reg, qb};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gwwb_pkg::LN_IDLE: if (start) state_next = gwwb_pkg::LN_MUL;
            gwwb_pkg::LN_MUL:  state_next = gwwb_pkg::LN_DIV;
            gwwb_pkg::LN_DIV:  if (cnt_reg == CW'(1)) state_next = gwwb_pkg::LN_DONE;
            gwwb_pkg::LN_DONE: if (start) state_next = gwwb_pkg::LN_MUL;
            default:           state_next = gwwb_pkg::LN_IDLE;
        endcase
    end

    always_comb begin
        num_next = num_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        sat_next = sat_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            gwwb_pkg::LN_MUL: begin
                num_next = {prod, 1'b0} + NW'({sum_reg, 1'b0}) + NW'(sum_reg);
                rem_next = '0;
                q_next   = '0;
                sat_next = 1'b0;
                cnt_next = CW'(NW);
            end
            gwwb_pkg::LN_DIV: begin
                num_next = {num_reg[NW-2:0], 1'b0};
                rem_next = qb ? DW'(rem_sh - {1'b0, div_w}) : rem_sh[DW-1:0];
                cnt_next = cnt_reg - CW'(1);
                if (!sat_reg) begin
                    if (qn[PIXEL_BITS]) sat_next = 1'b1;
                    else q_next = qn[PIXEL_BITS-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= gwwb_pkg::LN_IDLE;
        else state_reg <= state_next;
        if (start) begin
            pix_reg <= pix_in;
            tot_reg <= total_in;
            sum_reg <= sum_in;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
        cnt_reg <= cnt_next;
    end

    assign done   = state_reg == gwwb_pkg::LN_DONE;
    assign result = (sum_reg == '0) ? '0 : (sat_reg ? '1 : q_reg);
endmodule

// File: rtl/grey_world_white_balance.sv
// Top level: channel statistics, three parallel gain lanes and the merged result register.
// Clear and accumulate items update the statistics and result register directly. An apply item
// goes from acceptance to result through a product step, then one quotient bit per cycle in
// the bit-serial divider of each channel lane; the three lanes run side by side and the
// result is merged into one output register. Once the result is loaded, the input is ready
// again when the output register is free. Once 2^COUNT_BITS pixels are gathered, further
// accumulates are dropped with status 3.
module grey_world_white_balance #(
    parameter int COUNT_BITS = 24,
    parameter int PIXEL_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gwwb_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gwwb_pkg::out_item_t m_data
);
    localparam int SUM_BITS = PIXEL_BITS + COUNT_BITS;

    gwwb_pkg::top_state_t state_reg, state_next;
    logic [SUM_BITS-1:0]   sum0_reg, sum1_reg, sum2_reg;
    logic [COUNT_BITS:0]   count_reg;
    logic [SUM_BITS+1:0]   total;
    logic                  m_valid_reg;
    gwwb_pkg::out_item_t   out_reg;
    logic                  accept, out_free, lanes_done, start, load_apply;
    logic [2:0]            done_w;
    logic [PIXEL_BITS-1:0] res0, res1, res2;

    assign total    = (SUM_BITS+2)'(sum0_reg) + (SUM_BITS+2)'(sum1_reg)
                    + (SUM_BITS+2)'(sum2_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign lanes_done = &done_w;
    assign accept   = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gwwb_pkg::ST_IDLE: if (accept && s_data.cmd[1]) state_next = gwwb_pkg::ST_BUSY;
            gwwb_pkg::ST_BUSY: if (lanes_done && out_free) state_next = gwwb_pkg::ST_IDLE;
            default:           state_next = gwwb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        load_apply = 1'b0;
        case (state_reg)
            gwwb_pkg::ST_IDLE: s_ready = out_free;
            gwwb_pkg::ST_BUSY: load_apply = lanes_done && out_free;
            default: ;
        endcase
        start = accept && s_data.cmd[1];
    end

    gwwb_lane #(.PIXEL_BITS(PIXEL_BITS), .SUM_BITS(SUM_BITS)) u_lane0 (
        .aclk(aclk), .aresetn(aresetn), .start(start),
        .pix_in(s_data.chan0_in[PIXEL_BITS-1:0]), .total_in(total), .sum_in(sum0_reg),
        .done(done_w[0]), .result(res0));
    gwwb_lane #(.PIXEL_BITS(PIXEL_BITS), .SUM_BITS(SUM_BITS)) u_lane1 (
        .aclk(aclk), .aresetn(aresetn), .start(start),
        .pix_in(s_data.chan1_in[PIXEL_BITS-1:0]), .total_in(total), .sum_in(sum1_reg),
        .done(done_w[1]), .result(res1));
    gwwb_lane #(.PIXEL_BITS(PIXEL_BITS), .SUM_BITS(SUM_BITS)) u_lane2 (
        .aclk(aclk), .aresetn(aresetn), .start(start),
        .pix_in(s_data.chan2_in[PIXEL_BITS-1:0]), .total_in(total), .sum_in(sum2_reg),
        .done(done_w[2]), .result(res2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gwwb_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            sum0_reg    <= '0;
            sum1_reg    <= '0;
            sum2_reg    <= '0;
            count_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (load_apply) begin
                m_valid_reg       <= 1'b1;
                out_reg.chan0_out <= 16'(res0);
                out_reg.chan1_out <= 16'(res1);
                out_reg.chan2_out <= 16'(res2);
                out_reg.status    <= gwwb_pkg::STAT_APPLIED;
            end else if (accept && !s_data.cmd[1]) begin
                m_valid_reg <= 1'b1;
                out_reg.chan0_out <= '0;
                out_reg.chan1_out <= '0;
                out_reg.chan2_out <= '0;
                if (s_data.cmd == gwwb_pkg::CMD_ACCUM) begin
                    if (count_reg[COUNT_BITS]) begin
                        out_reg.status <= gwwb_pkg::STAT_DROPPED;
                    end else begin
                        sum0_reg  <= sum0_reg + SUM_BITS'(s_data.chan0_in[PIXEL_BITS-1:0]);
                        sum1_reg  <= sum1_reg + SUM_BITS'(s_data.chan1_in[PIXEL_BITS-1:0]);
                        sum2_reg  <= sum2_reg + SUM_BITS'(s_data.chan2_in[PIXEL_BITS-1:0]);
                        count_reg <= count_reg + (COUNT_BITS+1)'(1);
                        out_reg.status <= gwwb_pkg::STAT_ACCUM;
                    end
                end else begin
                    sum0_reg  <= '0;
                    sum1_reg  <= '0;
                    sum2_reg  <= '0;
                    count_reg <= '0;
                    out_reg.status <= gwwb_pkg::STAT_CLEARED;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
endmodule

// File: test/testbench.sv
// Testbench for grey_world_white_balance: directed table plus random items checked against a predictor.
module testbench;
    import gwwb_pkg::*;

    localparam logic [1:0] CMD_APPLY = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int COUNT_BITS = 24;
    localparam int PIXEL_BITS = 16;
    localparam int N_RANDOM = 1200;
    localparam int CYCLE_LIMIT = 2000000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_item_t s_data;
    logic m_valid;
    logic m_ready;
    out_item_t m_data;

    grey_world_white_balance dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    typedef struct {
        in_item_t item;
        logic     typed;
        out_item_t want;
    } stim_row_t;

    logic [39:0] acc0, acc1, acc2;
    logic [24:0] pix_seen;
    out_item_t   pending_q[$];
    int          mismatches;
    int          cycles;
    bit          stim_done;
    bit          hold_long;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("** grey_world_white_balance: FAILED **");
                $finish;
            end
        end
    end

    // round-half-up of p*total/(3*s), clamped
    function automatic logic [15:0] gain_channel(logic [15:0] p, logic [41:0] total,
                                                 logic [39:0] s);
        logic [127:0] num;
        logic [127:0] q;
        if (s == 0) return 16'd0;
        num = 2 * (128'(p) * 128'(total)) + 3 * 128'(s);
        q = num / (6 * 128'(s));
        if (q > 128'(16'hFFFF)) return 16'hFFFF;
        return q[15:0];
    endfunction

    function automatic out_item_t balance_predict(in_item_t it);
        out_item_t r;
        logic [41:0] total;
        r = '0;
        if (it.cmd[1]) begin
            total = 42'(acc0) + 42'(acc1) + 42'(acc2);
            r.chan0_out = gain_channel(it.chan0_in, total, acc0);
            r.chan1_out = gain_channel(it.chan1_in, total, acc1);
            r.chan2_out = gain_channel(it.chan2_in, total, acc2);
            r.status = STAT_APPLIED;
        end else if (it.cmd == CMD_ACCUM) begin
            if (pix_seen >= (25'd1 << COUNT_BITS)) begin
                r.status = STAT_DROPPED;
            end else begin
                acc0 = acc0 + 40'(it.chan0_in);
                acc1 = acc1 + 40'(it.chan1_in);
                acc2 = acc2 + 40'(it.chan2_in);
                pix_seen = pix_seen + 25'd1;
                r.status = STAT_ACCUM;
            end
        end else begin
            acc0 = '0; acc1 = '0; acc2 = '0; pix_seen = '0;
            r.status = STAT_CLEARED;
        end
        return r;
    endfunction

    function automatic in_item_t mk(logic [1:0] c, logic [15:0] a, logic [15:0] b,
                                    logic [15:0] d);
        in_item_t it;
        it.cmd = c; it.chan0_in = a; it.chan1_in = b; it.chan2_in = d;
        return it;
    endfunction

    function automatic out_item_t res(logic [15:0] a, logic [15:0] b, logic [15:0] d,
                                      logic [1:0] st);
        out_item_t r;
        r.chan0_out = a; r.chan1_out = b; r.chan2_out = d; r.status = st;
        return r;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 150);
    endfunction

    // checker: sample at rising edge
    always @(posedge aclk) begin
        out_item_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item %h", m_data);
            end else begin
                w = pending_q.pop_front();
                if (m_data.chan0_out !== w.chan0_out || m_data.chan1_out !== w.chan1_out ||
                    m_data.chan2_out !== w.chan2_out || m_data.status !== w.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h got %h", w, m_data);
                end
            end
        end
    end

    // receiver
    initial begin
        int g;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_long) begin
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_long = 1'b0;
            end
            g = gap_len();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g - 1) @(negedge aclk);
                @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    task automatic send_item(in_item_t it, logic typed, out_item_t want);
        out_item_t p;
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        p = balance_predict(it);
        pending_q.push_back(typed ? want : p);
        s_data <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin
        stim_row_t rows[$];
        in_item_t it;
        int k, i, n_acc;
        mismatches = 0;
        stim_done = 0;
        hold_long = 0;
        acc0 = '0; acc1 = '0; acc2 = '0; pix_seen = '0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        rows.push_back('{mk(CMD_APPLY, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1,
                         res(0, 0, 0, STAT_APPLIED)});
        rows.push_back('{mk(CMD_ACCUM, 16'hFFFF, 16'h0000, 16'h0001), 1,
                         res(0, 0, 0, STAT_ACCUM)});
        rows.push_back('{mk(CMD_APPLY, 16'hFFFF, 16'hFFFF, 16'h0001), 0, '0});
        rows.push_back('{mk(CMD_SPARE, 16'h8000, 16'h1234, 16'hFFFF), 0, '0});
        rows.push_back('{mk(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1,
                         res(0, 0, 0, STAT_CLEARED)});
        rows.push_back('{mk(CMD_ACCUM, 16'h1000, 16'h2000, 16'h3000), 0, '0});
        rows.push_back('{mk(CMD_ACCUM, 16'h1000, 16'h2000, 16'h3000), 0, '0});
        rows.push_back('{mk(CMD_APPLY, 16'h1000, 16'h2000, 16'h3000), 0, '0});
        rows.push_back('{mk(CMD_APPLY, 16'h0000, 16'h0000, 16'h0000), 0, '0});
        rows.push_back('{mk(CMD_APPLY, 16'hFFFF, 16'h0001, 16'hAAAA), 0, '0});
        rows.push_back('{mk(CMD_ACCUM, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0, '0});
        rows.push_back('{mk(CMD_APPLY, 16'h5555, 16'hFFFF, 16'h0001), 0, '0});
        rows.push_back('{mk(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000), 1,
                         res(0, 0, 0, STAT_CLEARED)});
        rows.push_back('{mk(CMD_ACCUM, 16'h0001, 16'hFFFF, 16'hFFFF), 0, '0});
        rows.push_back('{mk(CMD_APPLY, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0, '0});
        foreach (rows[r]) send_item(rows[r].item, rows[r].typed, rows[r].want);
        s_valid <= 1'b0;

        // pause until drained
        wait (pending_q.size() == 0);
        @(negedge aclk);

        // back-pressure: receiver holds off while items keep coming
        hold_long = 1'b1;

        i = 0;
        while (i < N_RANDOM) begin
            send_item(mk(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom)), 0, '0);
            i++;
            n_acc = $urandom_range(1, 12);
            for (k = 0; k < n_acc; k++) begin
                send_item(mk(CMD_ACCUM, 16'($urandom), 16'($urandom), 16'($urandom)), 0, '0);
                i++;
            end
            n_acc = $urandom_range(1, 15);
            for (k = 0; k < n_acc; k++) begin
                it = mk($urandom_range(0, 9) == 0 ? CMD_SPARE : CMD_APPLY,
                        16'($urandom), 16'($urandom), 16'($urandom));
                if ($urandom_range(0, 7) == 0) it.cmd = 2'($urandom_range(0, 3));
                send_item(it, 0, '0);
                i++;
            end
        end
        s_valid <= 1'b0;

        stim_done = 1;
        wait (pending_q.size() == 0);
        repeat (200) @(posedge aclk);
        if (mismatches == 0) begin
            $display("** grey_world_white_balance: PASSED **");
        end else begin
            $display("** grey_world_white_balance: FAILED **");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/gwwb_pkg.sv
rtl/gwwb_lane.sv
rtl/grey_world_white_balance.sv
test/testbench.sv
